@@ hdl/lpfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by the parser and the top level.
`default_nettype none

package lpfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [LenW-1:0] MaxFrameLenReset = 16'd2048;

  typedef enum logic [3:0] {
    PhLenLo = 4'b0001,
    PhLenHi = 4'b0010,
    PhPass  = 4'b0100,
    PhSkip  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic emit;
    logic last;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/lpfd_parser.sv @@
// Frame parser: length capture, size check and payload count for one request per step.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [lpfd_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic [lpfd_pkg::LenW-1:0]  max_frame_len_i,
  output lpfd_pkg::res_t                  res_o
);

  lpfd_pkg::phase_e              phase_q, phase_d;
  logic [lpfd_pkg::ByteW-1:0]    len_lo_q, len_lo_d;
  logic [lpfd_pkg::LenW-1:0]     exp_len_q, exp_len_d;
  logic [lpfd_pkg::LenW-1:0]     cnt_q, cnt_d;
  logic [lpfd_pkg::LenW-1:0]     cnt_inc;
  logic [lpfd_pkg::LenW-1:0]     new_len;
  logic                          at_end;

  assign cnt_inc = cnt_q + 16'd1;
  assign at_end  = (cnt_inc >= exp_len_q);
  assign new_len = {rx_byte_i, len_lo_q};

  always_comb begin
    phase_d   = phase_q;
    len_lo_d  = len_lo_q;
    exp_len_d = exp_len_q;
    cnt_d     = cnt_q;
    res_o     = '0;
    unique case (phase_q)
      lpfd_pkg::PhLenLo: begin
        len_lo_d = rx_byte_i;
        phase_d  = lpfd_pkg::PhLenHi;
      end
      lpfd_pkg::PhLenHi: begin
        exp_len_d = new_len;
        cnt_d     = '0;
        if (new_len == '0) begin
          phase_d = lpfd_pkg::PhLenLo;
        end else if (new_len > max_frame_len_i) begin
          phase_d = lpfd_pkg::PhSkip;
        end else begin
          phase_d = lpfd_pkg::PhPass;
        end
      end
      lpfd_pkg::PhPass: begin
        cnt_d      = cnt_inc;
        res_o.emit = 1'b1;
        res_o.last = at_end;
        if (at_end) begin
          phase_d   = lpfd_pkg::PhLenLo;
          exp_len_d = '0;
          cnt_d     = '0;
        end
      end
      lpfd_pkg::PhSkip: begin
        cnt_d = cnt_inc;
        if (at_end) begin
          phase_d   = lpfd_pkg::PhLenLo;
          exp_len_d = '0;
          cnt_d     = '0;
        end
      end
      default: begin
        phase_d   = lpfd_pkg::PhLenLo;
        exp_len_d = '0;
        cnt_d     = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lpfd_pkg::PhLenLo;
      len_lo_q  <= '0;
      exp_len_q <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      len_lo_q  <= len_lo_d;
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/length_prefixed_frame_deframer_unit.sv @@
// Top level of the length-prefixed frame deframer: input register, parser, output register.
// Depends on lpfd_pkg and lpfd_parser.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | rx_byte_i
//   out     | output    | out_valid_o / out_ready_i | payload_byte_o, last_of_frame_o
//   cfg     | input     | cfg_we_i (no wait)        | cfg_wdata_i (max_frame_len)
//
// One request per cycle unless the output stalls; a request is parsed as it leaves the
// input register, and its payload byte enters the output register at that same edge.
// The parser state advances once per request; length and dropped bytes give no result.
// Reset clears the parser to length-low, empties both registers, max_frame_len to 2048.
// A stalled output holds its request and the input register, ready drops only then.
`default_nettype none

module length_prefixed_frame_deframer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output wire logic                       in_ready_o,
  input  wire logic [lpfd_pkg::ByteW-1:0] rx_byte_i,
  output wire logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output wire logic [lpfd_pkg::ByteW-1:0] payload_byte_o,
  output wire logic                       last_of_frame_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [lpfd_pkg::LenW-1:0]  cfg_wdata_i
);

  logic                       in_vld_q;
  logic [lpfd_pkg::ByteW-1:0] in_byte_q;
  logic                       out_vld_q, out_vld_d;
  logic [lpfd_pkg::ByteW-1:0] out_byte_q;
  logic                       out_last_q;
  logic [lpfd_pkg::LenW-1:0]  max_len_q;
  logic                       out_free;
  logic                       advance;
  lpfd_pkg::res_t             res;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;

  lpfd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .rx_byte_i       (in_byte_q),
    .max_frame_len_i (max_len_q),
    .res_o           (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = advance && res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      max_len_q <= lpfd_pkg::MaxFrameLenReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res.emit) begin
      out_byte_q <= in_byte_q;
      out_last_q <= res.last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign payload_byte_o  = out_byte_q;
  assign last_of_frame_o = out_last_q;

endmodule

`default_nettype wire

@@ hdl/lpfd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
// Depends on length_prefixed_frame_deframer_unit port names only.
`default_nettype none

module lpfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] payload_byte_o,
  input wire logic       last_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(payload_byte_o) && $stable(last_of_frame_o))
    else $error("stalled result changed");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output is free");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind length_prefixed_frame_deframer_unit lpfd_checker u_lpfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .payload_byte_o  (payload_byte_o),
  .last_of_frame_o (last_of_frame_o)
);

`default_nettype wire
